[rtl/bitmap_page_frame_allocator_macros.svh]
// Assertion macros for the bitmap page frame allocator.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define BPFA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Check an implication in the cycle after the antecedent, outside reset.
`define BPFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/bpfa_pkg.sv]
// Shared constants of the bitmap page frame allocator.
`default_nettype none
package bpfa_pkg;
  localparam int NumFramesDefault = 32768;
  localparam int WordBitsDefault  = 32;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_RESERVE = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;
endpackage
`default_nettype wire

[rtl/bitmap_page_frame_allocator.sv]
// Allocate: each map word is read (SREAD) and scanned (SCAN) up to the word that closes the
// run, or to the last word if none does; then each marked word is read (MREAD) and written
// back (MOD). Free and reserve read and write back each touched word (MREAD, MOD); rejected
// items go straight to DONE. The next item is taken after the result is posted, even while the
// result waits; a later result holds in DONE until the result register is taken.
// After reset a clearing pass writes ones to every map word.
`default_nettype none
`include "bitmap_page_frame_allocator_macros.svh"
module bitmap_page_frame_allocator #(
  parameter int NUM_FRAMES = bpfa_pkg::NumFramesDefault,
  parameter int WORD_BITS  = bpfa_pkg::WordBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [19:0] frame_index,
  input  wire logic [15:0] frame_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             status,
  output logic [14:0]      first_frame,
  output logic [15:0]      free_frames
);
  localparam int MapWords = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW  = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int BW  = $clog2(WORD_BITS);
  localparam int FW  = $clog2(NUM_FRAMES + 1) + 1;
  localparam int PW  = BW + 1;
  localparam logic [FW-1:0] NumF = FW'(NUM_FRAMES);
  localparam logic [AW:0] LastWord = (AW+1)'(MapWords - 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SREAD = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_MREAD = 7'b0010000,
    S_MOD   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  logic [AW:0]  waddr_cnt;
  logic [1:0]   cur_op;
  logic [FW-1:0] range_lo, range_hi;   // frame range [lo, hi) to modify
  logic [FW-1:0] used_total;
  logic [FW-1:0] need;
  logic [FW-1:0] run_len, run_start;
  logic          fail;
  logic          op_was_alloc_n;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  bpfa_map_ram #(.Depth(MapWords), .Width(WORD_BITS)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // Word-level view of the current modify word
  logic [FW-1:0] word_base;
  logic [WORD_BITS-1:0] mask, new_word;
  logic [PW-1:0] delta;
  assign word_base = FW'(waddr_cnt[AW-1:0]) << BW;

  always_comb begin
    logic [FW-1:0] fr;
    mask  = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      fr = word_base + FW'(b);
      mask[b] = (fr >= range_lo) && (fr < range_hi);
    end
    if (cur_op == bpfa_pkg::OP_FREE) begin
      new_word = ram_rdata & ~mask;
      delta    = PW'($countones(ram_rdata & mask));
    end else begin
      new_word = ram_rdata | mask;
      delta    = PW'($countones(~ram_rdata & mask));
    end
  end

  // Scan: free run ending at each bit from the last used bit at or below it, lowest hit wins
  logic [FW-1:0] sc_len, sc_start;
  logic          sc_hit;
  always_comb begin
    logic [BW-1:0] lu;
    logic          seen;
    logic [FW-1:0] len;
    logic [FW-1:0] start;
    sc_len   = '0;
    sc_start = '0;
    sc_hit   = 1'b0;
    for (int b = 0; b < WORD_BITS; b++) begin
      seen = 1'b0;
      lu   = '0;
      for (int i = 0; i <= b; i++) begin
        if (ram_rdata[i]) begin
          seen = 1'b1;
          lu   = BW'(i);
        end
      end
      if (seen) begin
        len   = FW'(b) - FW'(lu);
        start = word_base + FW'(lu) + FW'(1);
      end else begin
        len   = run_len + FW'(b + 1);
        start = (run_len == '0) ? word_base : run_start;
      end
      if (!sc_hit && len >= need) begin
        sc_hit   = 1'b1;
        sc_start = start;
      end
      if (b == WORD_BITS - 1) begin
        sc_len = len;
        if (!sc_hit) sc_start = start;
      end
    end
  end

  logic [FW-1:0] req_hi;
  always_comb begin
    logic [FW:0] s;
    s = (FW+1)'(frame_index) + (FW+1)'(frame_count);
    req_hi = (s > (FW+1)'(NUM_FRAMES)) ? NumF : s[FW-1:0];
  end

  assign in_ready  = (state == S_IDLE);
  assign ram_raddr = waddr_cnt[AW-1:0];

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      waddr_cnt <= '0;
      used_total <= NumF;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          waddr_cnt <= waddr_cnt + 1'b1;
          if (waddr_cnt == LastWord) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cur_op <= op;
            fail <= 1'b0;
            run_len <= '0;
            run_start <= '0;
            need <= FW'(frame_count);
            if (op == bpfa_pkg::OP_ALLOC) begin
              waddr_cnt <= '0;
              if (frame_count == 16'd0 ||
                  FW'(frame_count) > NumF - used_total) begin
                fail <= 1'b1;
                state <= S_DONE;
              end else begin
                state <= S_SREAD;
              end
            end else if ((op == bpfa_pkg::OP_FREE || op == bpfa_pkg::OP_RESERVE)
                         && {1'b0, frame_index} < 21'(NUM_FRAMES)
                         && frame_count != 16'd0) begin
              range_lo  <= FW'(frame_index);
              range_hi  <= req_hi;
              waddr_cnt <= (AW+1)'(frame_index >> BW);
              state <= S_MREAD;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SREAD: state <= S_SCAN;
        S_SCAN: begin
          if (sc_hit) begin
            range_lo <= sc_start;
            range_hi <= sc_start + need;
            run_start <= sc_start;
            cur_op <= bpfa_pkg::OP_RESERVE;
            waddr_cnt <= (AW+1)'(sc_start >> BW);
            state <= S_MREAD;
          end else if (waddr_cnt == LastWord) begin
            fail <= 1'b1;
            state <= S_DONE;
          end else begin
            run_len <= sc_len;
            run_start <= sc_start;
            waddr_cnt <= waddr_cnt + 1'b1;
            state <= S_SREAD;
          end
        end
        S_MREAD: state <= S_MOD;
        S_MOD: begin
          if (cur_op == bpfa_pkg::OP_FREE) used_total <= used_total - FW'(delta);
          else used_total <= used_total + FW'(delta);
          if (word_base + FW'(WORD_BITS) >= range_hi || waddr_cnt == LastWord) begin
            state <= S_DONE;
          end else begin
            waddr_cnt <= waddr_cnt + 1'b1;
            state <= S_MREAD;
          end
        end
        S_DONE: begin
          // Hold until the result register is free or being taken
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status <= fail ? bpfa_pkg::STATUS_FAIL : bpfa_pkg::STATUS_OK;
            first_frame <= (fail || op_was_alloc_n) ? 15'd0 : run_start[14:0];
            free_frames <= 16'(NumF - used_total);
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // Remember whether the item was an allocation
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && in_ready) begin
      op_was_alloc_n <= (op != bpfa_pkg::OP_ALLOC);
    end
  end

  // Memory write: clear pass fills ones, modify writes back
  assign ram_we    = (state == S_CLEAR) || (state == S_MOD);
  assign ram_waddr = waddr_cnt[AW-1:0];
  assign ram_wdata = (state == S_CLEAR) ? '1 : new_word;

  `BPFA_ASSERT_IMP(a_no_accept_busy, clk, rst, in_valid && in_ready, state == S_IDLE, "item taken while busy")
  `BPFA_ASSERT_IMP(a_used_bound, clk, rst, 1'b1, used_total <= NumF, "used count beyond frame count")
  `BPFA_ASSERT_NEXT(a_done_valid, clk, rst, state == S_DONE, out_valid, "result not posted")
endmodule
`default_nettype wire

[rtl/bpfa_map_ram.sv]
// Used-map memory: one write port, one registered read port.
`default_nettype none
module bpfa_map_ram #(
  parameter int Depth = 1024,
  parameter int Width = 32,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [Width-1:0]   rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and read the array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[tb/tb_bitmap_page_frame_allocator.sv]
// Self-checking testbench for the bitmap page frame allocator: directed table plus random items.
`default_nettype none
module tb_bitmap_page_frame_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FRAMES     = 32768;
  localparam logic [1:0]  OP_UNKNOWN = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [19:0] idx;
    logic [15:0] cnt;
    bit          typed;
    logic        st;
    logic [14:0] first;
    logic [15:0] nfree;
  } stim_row_t;

  typedef struct {
    logic        st;
    logic [14:0] first;
    logic [15:0] nfree;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = bpfa_pkg::OP_ALLOC;
  logic [19:0] frame_index = '0;
  logic [15:0] frame_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        status;
  logic [14:0] first_frame;
  logic [15:0] free_frames;

  bit            frame_busy [FRAMES];
  int            busy_total;
  alloc_result_t pending_results [$];
  int            fail_count = 0;

  bitmap_page_frame_allocator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .frame_index(frame_index), .frame_count(frame_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .first_frame(first_frame), .free_frames(free_frames)
  );

  always #5 clk = ~clk;

  // Apply one operation to the frame map and return the result it gives.
  function automatic alloc_result_t apply_frame_op(logic [1:0] o, logic [19:0] idx,
                                                   logic [15:0] cnt);
    alloc_result_t r;
    int run_start;
    int run_len;
    bit found;
    int f;
    run_start = 0;
    run_len = 0;
    found = 0;
    r.st = bpfa_pkg::STATUS_OK;
    r.first = '0;
    if (o == bpfa_pkg::OP_ALLOC) begin
      if (cnt != 0 && int'(cnt) <= FRAMES - busy_total) begin
        for (f = 0; f < FRAMES && !found; f++) begin
          if (frame_busy[f]) begin
            run_len = 0;
          end else begin
            if (run_len == 0) run_start = f;
            run_len++;
            if (run_len == int'(cnt)) found = 1;
          end
        end
      end
      if (found) begin
        for (f = run_start; f < run_start + int'(cnt); f++) frame_busy[f] = 1;
        busy_total += int'(cnt);
        r.first = run_start[14:0];
      end else begin
        r.st = bpfa_pkg::STATUS_FAIL;
      end
    end else if (o == bpfa_pkg::OP_FREE || o == bpfa_pkg::OP_RESERVE) begin
      for (f = int'(idx); f < int'(idx) + int'(cnt) && f < FRAMES; f++) begin
        if (frame_busy[f] != (o == bpfa_pkg::OP_RESERVE)) begin
          frame_busy[f] = (o == bpfa_pkg::OP_RESERVE);
          busy_total += (o == bpfa_pkg::OP_RESERVE) ? 1 : -1;
        end
      end
    end
    r.nfree = 16'(FRAMES - busy_total);
    return r;
  endfunction

  // Drive one item after the given gap and wait until it is taken.
  task automatic send_item(logic [1:0] o, logic [19:0] idx, logic [15:0] cnt,
                           bit typed, alloc_result_t typed_res, int gap);
    alloc_result_t r;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= o;
    frame_index <= idx;
    frame_count <= cnt;
    do @(posedge clk); while (!in_ready);
    r = apply_frame_op(o, idx, cnt);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Stall the result side in bursts, with some long stalls.
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each taken result against the oldest expectation.
  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status=%0d first_frame=%0d free_frames=%0d",
               status, first_frame, free_frames);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, status);
          fail_count++;
        end
        if (first_frame !== e.first) begin
          $error("first_frame: expected %0d, got %0d", e.first, first_frame);
          fail_count++;
        end
        if (free_frames !== e.nfree) begin
          $error("free_frames: expected %0d, got %0d", e.nfree, free_frames);
          fail_count++;
        end
      end
    end
  end

  stim_row_t directed_rows [25] = '{
    '{bpfa_pkg::OP_ALLOC,   20'd0,     16'd1,     1, bpfa_pkg::STATUS_FAIL, 15'd0, 16'd0},
    '{bpfa_pkg::OP_ALLOC,   20'd0,     16'd0,     1, bpfa_pkg::STATUS_FAIL, 15'd0, 16'd0},
    '{bpfa_pkg::OP_FREE,    20'd0,     16'd0,     1, bpfa_pkg::STATUS_OK,   15'd0, 16'd0},
    '{OP_UNKNOWN,           20'hFFFFF, 16'hFFFF,  1, bpfa_pkg::STATUS_OK,   15'd0, 16'd0},
    '{bpfa_pkg::OP_FREE,    20'd0,     16'd64,    1, bpfa_pkg::STATUS_OK,   15'd0, 16'd64},
    '{bpfa_pkg::OP_ALLOC,   20'hFFFFF, 16'd16,    1, bpfa_pkg::STATUS_OK,   15'd0, 16'd48},
    '{bpfa_pkg::OP_ALLOC,   20'd0,     16'hFFFF,  1, bpfa_pkg::STATUS_FAIL, 15'd0, 16'd48},
    '{bpfa_pkg::OP_RESERVE, 20'd0,     16'd64,    1, bpfa_pkg::STATUS_OK,   15'd0, 16'd0},
    '{bpfa_pkg::OP_FREE,    20'hFFFFF, 16'hFFFF,  1, bpfa_pkg::STATUS_OK,   15'd0, 16'd0},
    '{bpfa_pkg::OP_FREE,    20'd32760, 16'd100,   1, bpfa_pkg::STATUS_OK,   15'd0, 16'd8},
    '{bpfa_pkg::OP_FREE,    20'd0,     16'd32768, 1, bpfa_pkg::STATUS_OK,   15'd0, 16'd32768},
    '{bpfa_pkg::OP_ALLOC,   20'd0,     16'd32768, 1, bpfa_pkg::STATUS_OK,   15'd0, 16'd0},
    '{bpfa_pkg::OP_FREE,    20'd0,     16'd32768, 1, bpfa_pkg::STATUS_OK,   15'd0, 16'd32768},
    '{bpfa_pkg::OP_RESERVE, 20'd0,     16'd32767, 1, bpfa_pkg::STATUS_OK,   15'd0, 16'd1},
    '{bpfa_pkg::OP_ALLOC,   20'd0,     16'd1,     1, bpfa_pkg::STATUS_OK, 15'd32767, 16'd0},
    '{bpfa_pkg::OP_FREE,    20'd0,     16'd32768, 1, bpfa_pkg::STATUS_OK,   15'd0, 16'd32768},
    '{bpfa_pkg::OP_RESERVE, 20'd100,   16'd1,     1, bpfa_pkg::STATUS_OK,   15'd0, 16'd32767},
    '{bpfa_pkg::OP_ALLOC,   20'd0,     16'd200,   1, bpfa_pkg::STATUS_OK, 15'd101, 16'd32567},
    '{bpfa_pkg::OP_ALLOC,   20'd0,     16'd32768, 1, bpfa_pkg::STATUS_FAIL, 15'd0, 16'd32567},
    '{bpfa_pkg::OP_ALLOC,   20'd0,     16'd100,   1, bpfa_pkg::STATUS_OK,   15'd0, 16'd32467},
    '{bpfa_pkg::OP_FREE,    20'd50,    16'd30,    0, bpfa_pkg::STATUS_OK,   15'd0, 16'd0},
    '{bpfa_pkg::OP_ALLOC,   20'd0,     16'd40,    0, bpfa_pkg::STATUS_OK,   15'd0, 16'd0},
    '{bpfa_pkg::OP_RESERVE, 20'd0,     16'd32768, 1, bpfa_pkg::STATUS_OK,   15'd0, 16'd0},
    '{bpfa_pkg::OP_FREE,    20'd0,     16'd4096,  1, bpfa_pkg::STATUS_OK,   15'd0, 16'd4096},
    '{bpfa_pkg::OP_FREE,    20'h20000, 16'd16,    1, bpfa_pkg::STATUS_OK,   15'd0, 16'd4096}
  };

  // Reset, walk the directed table, then random items.
  initial begin
    alloc_result_t tr;
    int p;
    logic [1:0]  o;
    logic [19:0] idx;
    logic [15:0] cnt;
    for (int f = 0; f < FRAMES; f++) frame_busy[f] = 1;
    busy_total = FRAMES;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      tr.st = directed_rows[i].st;
      tr.first = directed_rows[i].first;
      tr.nfree = directed_rows[i].nfree;
      send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].cnt,
                directed_rows[i].typed, tr, pick_gap());
    end
    // hold off until the whole directed part has drained
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    for (int n = 0; n < 560; n++) begin
      p = $urandom_range(0, 99);
      idx = 20'($urandom_range(0, 4095));
      cnt = 16'($urandom_range(1, 64));
      if (p < 55) begin
        o = bpfa_pkg::OP_ALLOC;
        cnt = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 600))
                                           : 16'($urandom_range(1, 32));
      end else if (p < 78) begin
        o = bpfa_pkg::OP_FREE;
        if ($urandom_range(0, 9) == 0) cnt = 16'($urandom_range(64, 512));
      end else if (p < 94) begin
        o = bpfa_pkg::OP_RESERVE;
      end else if (p < 98) begin
        o = ($urandom_range(0, 1) == 0) ? bpfa_pkg::OP_FREE : bpfa_pkg::OP_RESERVE;
        idx = 20'($urandom);
        cnt = 16'($urandom);
      end else begin
        o = OP_UNKNOWN;
        idx = 20'($urandom);
        cnt = 16'($urandom);
      end
      send_item(o, idx, cnt, 0, tr, (n % 100 < 20) ? 0 : pick_gap());
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("[bitmap_page_frame_allocator] OK");
    end else begin
      $display("[bitmap_page_frame_allocator] ERROR");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #200_000_000;
    $display("[bitmap_page_frame_allocator] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
